[hdl/svla_pkg.sv]
package svla_pkg;

  // Fixed-point format of every signed operand
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 2 ** FRAC_BITS;

  // Datapath widths; all but the accumulator sum widths derive from the 16-bit operand fields
  localparam int DOT_W  = 33;                           // sum of three 16x16 products
  localparam int SH_W   = DOT_W - FRAC_BITS;            // dot product after the shift
  localparam int D_W    = ((SH_W > 16) ? SH_W : 16) + 1; // plus bias
  localparam int GP_W   = D_W + 16;                     // d times gain
  localparam int GS_W   = GP_W - FRAC_BITS;             // gain product after the shift
  localparam int F_W    = FRAC_BITS + 2;                // factor clamped to [-ONE, ONE]
  localparam int CP_W   = F_W + 16;                     // factor times color
  localparam int TERM_W = CP_W - FRAC_BITS;             // color term after the shift
  localparam int SUM_W  = 24;
  localparam int ACC_W  = SUM_W + 1;

  localparam int SUM_MAX = 2 ** (SUM_W - 1) - 1;
  localparam int SUM_MIN = -(2 ** (SUM_W - 1));

  localparam logic [14:0] ALPHA_RESET = 15'd16384;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    CFG_NORMAL_X      = 3'd0,
    CFG_NORMAL_Y      = 3'd1,
    CFG_NORMAL_Z      = 3'd2,
    CFG_AMBIENT_RED   = 3'd3,
    CFG_AMBIENT_GREEN = 3'd4,
    CFG_AMBIENT_BLUE  = 3'd5,
    CFG_AMBIENT_ALPHA = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic               light_present;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] bias;
    logic signed [15:0] lit_gain;
    logic signed [15:0] shade_gain;
    logic signed [15:0] light_red;
    logic signed [15:0] light_green;
    logic signed [15:0] light_blue;
    logic               uses_ambient;
    logic               last_light;
  } light_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } color_req_t;

  // One classified light between the front and the back
  typedef struct packed {
    logic                light_present;
    logic                uses_ambient;
    logic                last_light;
    logic signed [D_W-1:0] d;
    logic signed [15:0]  gain;
    logic signed [15:0]  light_red;
    logic signed [15:0]  light_green;
    logic signed [15:0]  light_blue;
  } queue_entry_t;

endpackage

[hdl/svla_front.sv]
module svla_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [15:0]     normal_x,
  input  logic signed [15:0]     normal_y,
  input  logic signed [15:0]     normal_z,
  input  logic                   light_valid,
  output logic                   light_stall,
  input  svla_pkg::light_req_t   light,
  input  logic                   full,
  output logic                   push,
  output svla_pkg::queue_entry_t push_entry
);

  localparam int FRAC_BITS = svla_pkg::FRAC_BITS;
  localparam int DOT_W     = svla_pkg::DOT_W;
  localparam int SH_W      = svla_pkg::SH_W;
  localparam int D_W       = svla_pkg::D_W;

  logic                   advance;
  logic                   s1_valid;
  svla_pkg::light_req_t   s1_req;
  logic signed [31:0]     s1_px;
  logic signed [31:0]     s1_py;
  logic signed [31:0]     s1_pz;
  logic                   s2_valid;
  svla_pkg::queue_entry_t s2_entry;
  svla_pkg::queue_entry_t entry_next;
  logic signed [DOT_W-1:0] dot;
  logic signed [SH_W-1:0]  dot_sh;
  logic signed [D_W-1:0]   d;

  assign advance     = !s2_valid || !full;
  assign light_stall = !advance;
  assign push        = s2_valid && !full;
  assign push_entry  = s2_entry;

  // Sum the products, drop the fraction, add the bias and pick the gain side
  always_comb begin
    dot    = DOT_W'(s1_px) + DOT_W'(s1_py) + DOT_W'(s1_pz);
    dot_sh = dot[DOT_W-1:FRAC_BITS];
    d      = D_W'(dot_sh) + D_W'(s1_req.bias);
    entry_next.light_present = s1_req.light_present;
    entry_next.uses_ambient  = s1_req.uses_ambient;
    entry_next.last_light    = s1_req.last_light;
    entry_next.d             = d;
    entry_next.gain          = (d > 0) ? s1_req.lit_gain : s1_req.shade_gain;
    entry_next.light_red     = s1_req.light_red;
    entry_next.light_green   = s1_req.light_green;
    entry_next.light_blue    = s1_req.light_blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= light_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req   <= light;
      s1_px    <= normal_x * $signed(light.dir_x);
      s1_py    <= normal_y * $signed(light.dir_y);
      s1_pz    <= normal_z * $signed(light.dir_z);
      s2_entry <= entry_next;
    end
  end

endmodule

[hdl/svla_queue.sv]
module svla_queue #(
  parameter int DEPTH = svla_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  svla_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output svla_pkg::queue_entry_t pop_entry,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  svla_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !empty)
    else $error("queue lost a written entry");

endmodule

[hdl/svla_back.sv]
module svla_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [15:0]     ambient_red,
  input  logic signed [15:0]     ambient_green,
  input  logic signed [15:0]     ambient_blue,
  input  logic [14:0]            ambient_alpha,
  input  logic                   empty,
  input  svla_pkg::queue_entry_t pop_entry,
  output logic                   pop,
  output logic                   color_valid,
  input  logic                   color_stall,
  output svla_pkg::color_req_t   color
);

  localparam int FRAC_BITS = svla_pkg::FRAC_BITS;
  localparam int ONE       = svla_pkg::ONE;
  localparam int GP_W      = svla_pkg::GP_W;
  localparam int GS_W      = svla_pkg::GS_W;
  localparam int F_W       = svla_pkg::F_W;
  localparam int CP_W      = svla_pkg::CP_W;
  localparam int TERM_W    = svla_pkg::TERM_W;
  localparam int SUM_W     = svla_pkg::SUM_W;
  localparam int ACC_W     = svla_pkg::ACC_W;
  localparam int SUM_MAX   = svla_pkg::SUM_MAX;
  localparam int SUM_MIN   = svla_pkg::SUM_MIN;
  localparam int BYTE_W    = FRAC_BITS + 9;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  a,
    input logic signed [TERM_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = ACC_W'(a) + ACC_W'(b);
    if (s > SUM_MAX) begin
      return SUM_W'(SUM_MAX);
    end else if (s < SUM_MIN) begin
      return SUM_W'(SUM_MIN);
    end
    return s[SUM_W-1:0];
  endfunction

  // Clamp to [0, ONE] and scale by 255, truncating
  function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] v);
    logic [FRAC_BITS:0]  c;
    logic [BYTE_W-1:0]   m;
    if (v < 0) begin
      c = '0;
    end else if (v > ONE) begin
      c = (FRAC_BITS + 1)'(ONE);
    end else begin
      c = v[FRAC_BITS:0];
    end
    m = {c, 8'b0} - BYTE_W'(c);
    return m[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic back_en;

  // Stage 1: d times gain
  logic                    b1_valid;
  logic                    b1_present;
  logic                    b1_uses_ambient;
  logic                    b1_last;
  logic signed [GP_W-1:0]  b1_gp;
  logic signed [15:0]      b1_col [3];

  // Stage 2: clamped factor times each color
  logic                    b2_valid;
  logic                    b2_present;
  logic                    b2_uses_ambient;
  logic                    b2_last;
  logic signed [CP_W-1:0]  b2_prod [3];
  logic signed [GS_W-1:0]  gs;
  logic signed [F_W-1:0]   f;

  // Stage 3: accumulate, and snapshot the sums on the last light
  logic signed [SUM_W-1:0] amb_sum  [3];
  logic signed [SUM_W-1:0] ext_sum  [3];
  logic signed [SUM_W-1:0] amb_next [3];
  logic signed [SUM_W-1:0] ext_next [3];
  logic signed [TERM_W-1:0] term    [3];
  logic                    snap_valid;
  logic signed [SUM_W-1:0] snap_amb [3];
  logic signed [SUM_W-1:0] snap_ext [3];

  // Stage 4: final color
  logic signed [15:0]      amb_floor [3];
  logic signed [SUM_W-1:0] floored   [3];
  logic signed [ACC_W-1:0] total     [3];
  svla_pkg::color_req_t    color_next;

  assign back_en = !color_valid || !color_stall;
  assign pop     = back_en && !empty;

  always_comb begin
    gs = b1_gp[GP_W-1:FRAC_BITS];
    if (gs > ONE) begin
      f = F_W'(ONE);
    end else if (gs < -ONE) begin
      f = F_W'(-ONE);
    end else begin
      f = gs[F_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k]     = b2_prod[k][CP_W-1:FRAC_BITS];
      amb_next[k] = amb_sum[k];
      ext_next[k] = ext_sum[k];
      if (b2_valid && b2_present) begin
        if (b2_uses_ambient) begin
          amb_next[k] = sat_add(amb_sum[k], term[k]);
        end else begin
          ext_next[k] = sat_add(ext_sum[k], term[k]);
        end
      end
    end
  end

  always_comb begin
    amb_floor[0] = ambient_red;
    amb_floor[1] = ambient_green;
    amb_floor[2] = ambient_blue;
    for (int k = 0; k < 3; k++) begin
      floored[k] = (snap_amb[k] < amb_floor[k]) ? SUM_W'(amb_floor[k]) : snap_amb[k];
      total[k]   = ACC_W'(floored[k]) + ACC_W'(snap_ext[k]);
    end
    color_next.out_red   = to_byte(total[0]);
    color_next.out_green = to_byte(total[1]);
    color_next.out_blue  = to_byte(total[2]);
    color_next.out_alpha = to_byte($signed(ACC_W'(ambient_alpha)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid    <= 1'b0;
      b2_valid    <= 1'b0;
      snap_valid  <= 1'b0;
      color_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        amb_sum[k] <= '0;
        ext_sum[k] <= '0;
      end
    end else if (back_en) begin
      b1_valid    <= !empty;
      b2_valid    <= b1_valid;
      snap_valid  <= b2_valid && b2_last;
      color_valid <= snap_valid;
      for (int k = 0; k < 3; k++) begin
        if (b2_valid && b2_last) begin
          amb_sum[k] <= '0;
          ext_sum[k] <= '0;
        end else begin
          amb_sum[k] <= amb_next[k];
          ext_sum[k] <= ext_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      b1_present      <= pop_entry.light_present;
      b1_uses_ambient <= pop_entry.uses_ambient;
      b1_last         <= pop_entry.last_light;
      b1_gp           <= pop_entry.d * pop_entry.gain;
      b1_col[0]       <= pop_entry.light_red;
      b1_col[1]       <= pop_entry.light_green;
      b1_col[2]       <= pop_entry.light_blue;
      b2_present      <= b1_present;
      b2_uses_ambient <= b1_uses_ambient;
      b2_last         <= b1_last;
      for (int k = 0; k < 3; k++) begin
        b2_prod[k]  <= f * b1_col[k];
        snap_amb[k] <= amb_next[k];
        snap_ext[k] <= ext_next[k];
      end
      if (snap_valid) begin
        color <= color_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (back_en && b2_valid && b2_last) |=> snap_valid)
    else $error("last light did not reach the snapshot");
  assert property (@(posedge clk) disable iff (rst)
    (back_en && b2_valid && b2_last) |=> (amb_sum[0] == '0 && ext_sum[0] == '0))
    else $error("sums not cleared after a vertex");
  assert property (@(posedge clk) disable iff (rst)
    (back_en && snap_valid) |=> color_valid)
    else $error("snapshot dropped before the output register");

endmodule

[hdl/sprite_vertex_light_accumulator_core.sv]
// Two-sided diffuse vertex lighting. Write the surface normal and the ambient
// RGBA over the cfg port while the block is idle, then stream the lights of one
// vertex as requests on the light channel, one per clock; the request flagged
// last_light closes the vertex and, once it has passed the front, the queue and
// the back, one color request with the RGBA bytes appears on the color channel.
// Requests without light_present accumulate nothing but can still close a vertex.
// Sustained rate is one light per clock: the front computes the dot product,
// bias and gain side in two stages, a small queue parts it from the back, and
// the back runs gain multiply, factor clamp and color multiply, saturating
// accumulate and final byte conversion in four stages. light_stall rises only
// when the queue is full because the color request is being held by the sink.
module sprite_vertex_light_accumulator_core #(
  parameter int QUEUE_DEPTH = svla_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 light_valid,
  output logic                 light_stall,
  input  svla_pkg::light_req_t light,
  output logic                 color_valid,
  input  logic                 color_stall,
  output svla_pkg::color_req_t color
);

  // Configuration registers
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] ambient_red;
  logic signed [15:0] ambient_green;
  logic signed [15:0] ambient_blue;
  logic [14:0]        ambient_alpha;

  // Front to queue, queue to back
  logic                   push;
  svla_pkg::queue_entry_t push_entry;
  logic                   pop;
  svla_pkg::queue_entry_t pop_entry;
  logic                   full;
  logic                   empty;

  // Decode the write index; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x      <= '0;
      normal_y      <= '0;
      normal_z      <= '0;
      ambient_red   <= '0;
      ambient_green <= '0;
      ambient_blue  <= '0;
      ambient_alpha <= svla_pkg::ALPHA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        svla_pkg::CFG_NORMAL_X:      normal_x      <= cfg_data;
        svla_pkg::CFG_NORMAL_Y:      normal_y      <= cfg_data;
        svla_pkg::CFG_NORMAL_Z:      normal_z      <= cfg_data;
        svla_pkg::CFG_AMBIENT_RED:   ambient_red   <= cfg_data;
        svla_pkg::CFG_AMBIENT_GREEN: ambient_green <= cfg_data;
        svla_pkg::CFG_AMBIENT_BLUE:  ambient_blue  <= cfg_data;
        svla_pkg::CFG_AMBIENT_ALPHA: ambient_alpha <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Front: accept lights, form the biased dot product and pick the gain side
  svla_front u_front (
    .clk        (clk),
    .rst        (rst),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .light_valid(light_valid),
    .light_stall(light_stall),
    .light      (light),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: absorb lights while the back holds a color request
  svla_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .pop_entry (pop_entry),
    .full      (full),
    .empty     (empty)
  );

  // Back: scale, clamp, accumulate and convert the finished vertex
  svla_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ambient_red  (ambient_red),
    .ambient_green(ambient_green),
    .ambient_blue (ambient_blue),
    .ambient_alpha(ambient_alpha),
    .empty        (empty),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .color        (color)
  );

endmodule
